/* rtl/hwd_pkg.sv */
// Shared types, constants and the microcode program of the tree walk decoder.
package hwd_pkg;

    localparam int TREE_NODES    = 128;
    localparam int NODE_W        = 7;
    localparam int NODE_AW       = $clog2(TREE_NODES);
    localparam int SYM_W         = 7;
    localparam int BYTE_W        = 8;
    localparam int HELD_N        = 3;
    localparam int BITS_PER_BYTE = 8;
    localparam int CNT_W         = $clog2(BITS_PER_BYTE + 1);

    typedef logic [NODE_W-1:0]   node_t;
    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [SYM_W-1:0]    sym_t;
    typedef logic [2*BYTE_W-1:0] tree_word_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [1:0]          sel_t;
    typedef logic [1:0]          hcnt_t;

    // action codes
    localparam logic ACT_TREE = 1'b0;
    localparam logic ACT_CODE = 1'b1;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_WALK,
        OP_EMIT,
        OP_FLUSH,
        OP_END
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_START,
        C_SYM4,
        C_MORE_WALK,
        C_MORE,
        C_SKIP
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE   = 4'd0;
    localparam step_t STEP_WALK   = 4'd1;
    localparam step_t STEP_EMIT0  = 4'd2;
    localparam step_t STEP_EMIT1  = 4'd3;
    localparam step_t STEP_EMIT2  = 4'd4;
    localparam step_t STEP_FLUSH0 = 4'd5;
    localparam step_t STEP_FLUSH1 = 4'd6;
    localparam step_t STEP_FLUSH2 = 4'd7;
    localparam step_t STEP_END    = 4'd8;

    // control word: first hit of cond_a, cond_b picks the target, else nxt
    typedef struct packed {
        op_t   op;
        sel_t  sel;
        cond_t cond_a;
        step_t tgt_a;
        cond_t cond_b;
        step_t tgt_b;
        step_t nxt;
    } uword_t;

    // sequencer to datapath
    typedef struct packed {
        op_t  op;
        sel_t sel;
    } ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic start;
        logic sym4;
        logic cnt_one;
        logic cnt_zero;
        logic skip;
        logic stall;
    } stat_t;

    function automatic uword_t ucode(step_t s);
        uword_t w;
        unique case (s)
            STEP_IDLE:   w = '{OP_IDLE,  2'd0, C_START, STEP_WALK,
                               C_NEVER, STEP_IDLE, STEP_IDLE};
            STEP_WALK:   w = '{OP_WALK,  2'd0, C_SYM4, STEP_EMIT0,
                               C_MORE_WALK, STEP_WALK, STEP_FLUSH0};
            STEP_EMIT0:  w = '{OP_EMIT,  2'd0, C_NEVER, STEP_IDLE,
                               C_NEVER, STEP_IDLE, STEP_EMIT1};
            STEP_EMIT1:  w = '{OP_EMIT,  2'd1, C_NEVER, STEP_IDLE,
                               C_NEVER, STEP_IDLE, STEP_EMIT2};
            STEP_EMIT2:  w = '{OP_EMIT,  2'd2, C_MORE, STEP_WALK,
                               C_NEVER, STEP_IDLE, STEP_FLUSH0};
            STEP_FLUSH0: w = '{OP_FLUSH, 2'd0, C_SKIP, STEP_END,
                               C_NEVER, STEP_IDLE, STEP_FLUSH1};
            STEP_FLUSH1: w = '{OP_FLUSH, 2'd1, C_SKIP, STEP_END,
                               C_NEVER, STEP_IDLE, STEP_FLUSH2};
            STEP_FLUSH2: w = '{OP_FLUSH, 2'd2, C_SKIP, STEP_END,
                               C_NEVER, STEP_IDLE, STEP_END};
            STEP_END:    w = '{OP_END,   2'd0, C_NEVER, STEP_IDLE,
                               C_NEVER, STEP_IDLE, STEP_IDLE};
            default:     w = '{OP_IDLE,  2'd0, C_NEVER, STEP_IDLE,
                               C_NEVER, STEP_IDLE, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* rtl/hwd_if.sv */
// Request and result channel interfaces.
interface hwd_in_if import hwd_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  action;
    node_t node_index;
    byte_t left_child;
    byte_t right_child;
    byte_t code_byte;
    logic  end_of_stream;

    modport source (
        output valid, action, node_index, left_child, right_child, code_byte,
               end_of_stream,
        input  ready
    );
    modport sink (
        input  valid, action, node_index, left_child, right_child, code_byte,
               end_of_stream,
        output ready
    );
endinterface

interface hwd_out_if import hwd_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  byte_valid;
    logic  run_last;
    logic  stream_done;

    modport source (
        output valid, out_byte, byte_valid, run_last, stream_done,
        input  ready
    );
    modport sink (
        input  valid, out_byte, byte_valid, run_last, stream_done,
        output ready
    );
endinterface

/* rtl/hwd_seq.sv */
// Microcode sequencer: step counter, control ROM and jump conditions.
module hwd_seq import hwd_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    step_t  upc_reg;
    step_t  upc_next;
    uword_t cw;

    function automatic logic cond_hit(cond_t c, stat_t s);
        logic hit;
        unique case (c)
            C_NEVER:     hit = 1'b0;
            C_START:     hit = s.start;
            C_SYM4:      hit = s.sym4;
            C_MORE_WALK: hit = !s.cnt_one;
            C_MORE:      hit = !s.cnt_zero;
            C_SKIP:      hit = s.skip;
            default:     hit = 1'b0;
        endcase
        return hit;
    endfunction

    always_comb
    begin
        cw       = ucode(upc_reg);
        ctrl.op  = cw.op;
        ctrl.sel = cw.sel;
        priority if (stat.stall)
        begin
            upc_next = upc_reg;
        end
        else if (cond_hit(cw.cond_a, stat))
        begin
            upc_next = cw.tgt_a;
        end
        else if (cond_hit(cw.cond_b, stat))
        begin
            upc_next = cw.tgt_b;
        end
        else
        begin
            upc_next = cw.nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* rtl/hwd_dp.sv */
// Datapath: tree memory, walk cursor, held symbols, result staging and output.
module hwd_dp import hwd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    hwd_in_if.sink    in_ch,
    hwd_out_if.source out_ch,
    input  ctrl_t     ctrl,
    output stat_t     stat
);

    tree_word_t tree_mem [TREE_NODES];
    tree_word_t rd_data_reg;

    node_t cursor_reg;
    byte_t code_reg;
    cnt_t  cnt_reg;
    logic  eos_reg;
    sym_t  held_reg [HELD_N];
    hcnt_t hc_reg;
    sym_t  sym_reg;

    logic  pend_valid_reg;
    byte_t pend_byte_reg;

    logic  out_valid_reg;
    byte_t out_byte_reg;
    logic  out_bv_reg;
    logic  out_last_reg;
    logic  out_done_reg;

    logic  accept;
    logic  start;
    logic  walk;
    byte_t child;
    logic  is_sym;
    node_t next_node;
    node_t rd_addr;
    logic  rd_in_range;
    logic  wr_in_range;
    logic  out_free;
    logic  push_ok;
    logic  skip;
    logic  push_req;
    logic  end_req;
    logic  stall;
    logic  push;
    logic  fin;
    sym_t  held_sel;
    logic [1:0] pair;
    byte_t push_byte;

    assign in_ch.ready = (ctrl.op == OP_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign start       = accept && (in_ch.action == ACT_CODE);
    assign walk        = (ctrl.op == OP_WALK);

    // one tree step: bit 1 takes the left child (high byte)
    assign child     = code_reg[BYTE_W-1] ? rd_data_reg[2*BYTE_W-1:BYTE_W]
                                          : rd_data_reg[BYTE_W-1:0];
    assign is_sym    = child[SYM_W];
    assign next_node = is_sym ? '0 : node_t'(child[SYM_W-1:0]);
    assign rd_addr   = walk ? next_node : cursor_reg;

    assign rd_in_range = {1'b0, rd_addr} < (NODE_W+1)'(TREE_NODES);
    assign wr_in_range = {1'b0, in_ch.node_index} < (NODE_W+1)'(TREE_NODES);

    always_ff @(posedge clk)
    begin
        if (accept && (in_ch.action == ACT_TREE) && wr_in_range)
        begin
            tree_mem[in_ch.node_index[NODE_AW-1:0]] <=
                {in_ch.left_child, in_ch.right_child};
        end
        rd_data_reg <= rd_in_range ? tree_mem[rd_addr[NODE_AW-1:0]] : '0;
    end

    always_comb
    begin
        unique case (ctrl.sel)
            2'd0:    begin held_sel = held_reg[0]; pair = sym_reg[5:4]; end
            2'd1:    begin held_sel = held_reg[1]; pair = sym_reg[3:2]; end
            default: begin held_sel = held_reg[2]; pair = sym_reg[1:0]; end
        endcase
    end

    assign out_free = !out_valid_reg || out_ch.ready;
    assign push_ok  = !pend_valid_reg || out_free;
    assign skip     = !eos_reg || (hc_reg <= ctrl.sel);
    assign push_req = (ctrl.op == OP_EMIT) || ((ctrl.op == OP_FLUSH) && !skip);
    assign end_req  = (ctrl.op == OP_END) && (pend_valid_reg || eos_reg);
    assign stall    = (push_req && !push_ok) || (end_req && !out_free);
    assign push     = push_req && !stall;
    assign fin      = end_req && !stall;

    // top bits only on a completed group; bit 6 of the held symbol is OR-ed
    assign push_byte = (ctrl.op == OP_EMIT)
                       ? ({1'b0, held_sel} | {pair, 6'b0})
                       : {1'b0, held_sel};

    assign stat.start    = start;
    assign stat.sym4     = is_sym && (hc_reg == hcnt_t'(HELD_N));
    assign stat.cnt_one  = (cnt_reg == cnt_t'(1));
    assign stat.cnt_zero = (cnt_reg == '0);
    assign stat.skip     = skip;
    assign stat.stall    = stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            cnt_reg        <= '0;
            hc_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                cnt_reg <= cnt_t'(BITS_PER_BYTE);
            end
            else if (walk)
            begin
                cnt_reg <= cnt_reg - cnt_t'(1);
            end

            if (walk)
            begin
                cursor_reg <= next_node;
                if (is_sym)
                begin
                    hc_reg <= (hc_reg == hcnt_t'(HELD_N)) ? '0 : hc_reg + hcnt_t'(1);
                end
            end
            else if (fin && eos_reg)
            begin
                cursor_reg <= '0;
                hc_reg     <= '0;
            end

            if (push)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (fin)
            begin
                pend_valid_reg <= 1'b0;
            end

            if ((push && pend_valid_reg) || fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            code_reg <= in_ch.code_byte;
            eos_reg  <= in_ch.end_of_stream;
        end
        else if (walk)
        begin
            code_reg <= {code_reg[BYTE_W-2:0], 1'b0};
        end

        if (walk && is_sym)
        begin
            if (hc_reg == hcnt_t'(HELD_N))
            begin
                sym_reg <= child[SYM_W-1:0];
            end
            for (int i = 0; i < HELD_N; i++)
            begin
                if (hc_reg == hcnt_t'(i))
                begin
                    held_reg[i] <= child[SYM_W-1:0];
                end
            end
        end

        if (push)
        begin
            pend_byte_reg <= push_byte;
        end

        if (push && pend_valid_reg)
        begin
            out_byte_reg <= pend_byte_reg;
            out_bv_reg   <= 1'b1;
            out_last_reg <= 1'b0;
            out_done_reg <= 1'b0;
        end
        else if (fin)
        begin
            out_byte_reg <= pend_valid_reg ? pend_byte_reg : '0;
            out_bv_reg   <= pend_valid_reg;
            out_last_reg <= 1'b1;
            out_done_reg <= eos_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.byte_valid  = out_bv_reg;
    assign out_ch.run_last    = out_last_reg;
    assign out_ch.stream_done = out_done_reg;

endmodule

/* rtl/huffman_tree_walk_decoder_top.sv */
// Top level of the Huffman tree walk decoder.
//
// Usage: requests arrive on in_ch (valid/ready). A request with action 0
// writes one tree node (left child in the high byte, right in the low). A
// request with action 1 carries one code byte, walked MSB first from the
// current node; bit 7 of a child marks a 7-bit symbol.
// Every fourth symbol completes three held bytes, which go out on out_ch.
// end_of_stream flushes held bytes (or a bare end marker if none) and
// returns the walk to the root for the next stream with the same tree.
//
// Sequence: a code byte occupies the block for an accept step, a walk step
// per code bit (one tree bit per cycle, set by the registered tree read feeding
// the next address), the emit steps of each completed group, flush steps (one
// without an end flag, else one more than the held bytes, at most 3) and a
// closing step. in_ch.ready is high only when idle.
//
// Results pass a one-entry staging register (so run_last can be set on the
// last one) and then the output register. When out_ch stalls, the sequencer
// holds its step. Reset empties both registers, clears the cursor and the
// held count; tree contents are undefined until written.
module huffman_tree_walk_decoder_top import hwd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    hwd_in_if.sink    in_ch,
    hwd_out_if.source out_ch
);

    ctrl_t ctrl;   // current control word fields
    stat_t stat;   // datapath flags for jumps and stalls

    hwd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    hwd_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .ctrl   (ctrl),
        .stat   (stat)
    );

endmodule

/* rtl/hwd_check.sv */
// Port-level checker for the decoder output channel and its bind.
module hwd_check import hwd_pkg::*; (
    input logic  clk,
    input logic  rst_n,
    input logic  out_valid,
    input logic  out_ready,
    input byte_t out_byte,
    input logic  byte_valid,
    input logic  run_last,
    input logic  stream_done
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(byte_valid)
            && $stable(run_last) && $stable(stream_done))
        else $error("result changed while stalled");

    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> run_last && stream_done && (out_byte == '0))
        else $error("bare end marker malformed");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_done |-> run_last)
        else $error("stream end without run_last");

endmodule

bind huffman_tree_walk_decoder_top hwd_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .byte_valid  (out_ch.byte_valid),
    .run_last    (out_ch.run_last),
    .stream_done (out_ch.stream_done)
);
